// ----- hw/rtl/pla_pkg.sv -----
package pla_pkg;

	// Width of the reported total; the running total is cut or widened to this.
	localparam int OUT_WIDTH = 48;

	// Request command codes.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SQUARE = 4'b0010,
		ST_ROOT   = 4'b0100,
		ST_ACCUM  = 4'b1000
	} pla_state_t;

endpackage

// ----- hw/rtl/path_length_accumulator.sv -----
// 3D path length odometer. Each request carries a command and a signed Q16.16 position.
// A sample request (command 0) adds the Euclidean distance to the previously stored
// position to a running unsigned Q32.16 total and returns the new total as one result.
// A clear request (command 1) zeroes the total, keeps the stored position and returns
// nothing. The first sample after reset only records the position and reports the total.
// Both channels use valid/ready; a request is taken only while the sequencer is idle.
// A sample with a stored position runs through radix-4 squaring (three shift-add
// multipliers summed into one accumulator), radix-4 square root and a final add and
// saturate. RT_W is POS_WIDTH+1 rounded up to even. A sample is worked on to the end
// before the next request is taken. A first sample skips squaring and root and goes
// straight to the add; a clear request is done while the sequencer stays idle.
// The result sits in an output register. If the receiver stalls, the next request is
// still accepted and worked on; it waits in its final add cycle until the output
// register is free, so no result is lost or overwritten.
// Asynchronous reset clears the total, forgets the stored position and drops any
// pending result.
module path_length_accumulator #(
	parameter int POS_WIDTH   = 32,
	parameter int TOTAL_WIDTH = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          request_valid,
	output logic                          request_ready,
	input  logic                          command,
	input  logic [POS_WIDTH-1:0]          pos_x,
	input  logic [POS_WIDTH-1:0]          pos_y,
	input  logic [POS_WIDTH-1:0]          pos_z,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [pla_pkg::OUT_WIDTH-1:0] total_distance
);

	// Root width: the sum of three squares needs 2*POS_WIDTH+2 bits, its root
	// POS_WIDTH+1 bits. Rounded up to even so both loops take two bits a cycle.
	localparam int RT_W   = ((POS_WIDTH + 2) / 2) * 2;
	localparam int HI_W   = POS_WIDTH + 2;
	localparam int RAD_W  = 2 * RT_W;
	localparam int REM_W  = RT_W + 2;
	localparam int TRY_W  = RT_W + 4;
	localparam int PASSES = RT_W / 2;
	localparam int CNT_W  = $clog2(PASSES);
	localparam int SUM_W  = ((TOTAL_WIDTH > RT_W) ? TOTAL_WIDTH : RT_W) + 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PASSES - 1);

	pla_pkg::pla_state_t state_q;

	logic [POS_WIDTH-1:0]   prev_x_q, prev_y_q, prev_z_q;
	logic                   have_prev_q;
	logic [TOTAL_WIDTH-1:0] total_q;

	// Squaring: multiplicands held, multipliers shifted out two bits a cycle.
	logic [POS_WIDTH-1:0] dx_q, dy_q, dz_q;
	logic [RT_W-1:0]      mx_q, my_q, mz_q;
	logic [HI_W-1:0]      hi_q;
	logic [RT_W-1:0]      lo_q;

	// Square root: radicand shifted out two bits per step.
	logic [RAD_W-1:0] rad_q;
	logic [RT_W-1:0]  root_q;
	logic [REM_W-1:0] rem_q;

	logic [CNT_W-1:0] cnt_q;

	logic                          result_valid_q;
	logic [pla_pkg::OUT_WIDTH-1:0] result_q;

	logic accept;
	logic is_clear;
	logic out_free;

	logic [POS_WIDTH-1:0] ad_x, ad_y, ad_z;

	logic [HI_W:0]   sq_sum;
	logic [HI_W-1:0] sq_hi;
	logic [RT_W-1:0] sq_lo, sq_mx, sq_my, sq_mz;

	logic [TRY_W-1:0] rt_cur, rt_try;
	logic [RAD_W-1:0] rt_rad;
	logic [RT_W-1:0]  rt_root;
	logic [REM_W-1:0] rt_rem;

	logic [SUM_W-1:0]       acc_sum;
	logic [TOTAL_WIDTH-1:0] acc_next;

	// Magnitude of the difference of two two's complement positions.
	function automatic logic [POS_WIDTH-1:0] abs_diff(input logic [POS_WIDTH-1:0] a,
		input logic [POS_WIDTH-1:0] b);
		logic signed [POS_WIDTH:0] d;
		d = $signed({a[POS_WIDTH-1], a}) - $signed({b[POS_WIDTH-1], b});
		abs_diff = d[POS_WIDTH] ? POS_WIDTH'(-d) : POS_WIDTH'(d);
	endfunction

	assign request_ready  = (state_q == pla_pkg::ST_IDLE);
	assign accept         = request_valid && request_ready;
	assign is_clear       = (command == pla_pkg::CMD_CLEAR);
	assign out_free       = !result_valid_q || result_ready;
	assign result_valid   = result_valid_q;
	assign total_distance = result_q;

	assign ad_x = abs_diff(pos_x, prev_x_q);
	assign ad_y = abs_diff(pos_y, prev_y_q);
	assign ad_z = abs_diff(pos_z, prev_z_q);

	// Two shift-add steps per cycle. The high part adds the selected multiplicands
	// of all three axes, so the accumulator ends as dx*dx + dy*dy + dz*dz.
	always_comb begin
		sq_hi  = hi_q;
		sq_lo  = lo_q;
		sq_mx  = mx_q;
		sq_my  = my_q;
		sq_mz  = mz_q;
		sq_sum = '0;
		for (int j = 0; j < 2; j++) begin
			sq_sum = {1'b0, sq_hi}
				+ (HI_W + 1)'(sq_mx[0] ? dx_q : '0)
				+ (HI_W + 1)'(sq_my[0] ? dy_q : '0)
				+ (HI_W + 1)'(sq_mz[0] ? dz_q : '0);
			sq_lo = {sq_sum[0], sq_lo[RT_W-1:1]};
			sq_hi = sq_sum[HI_W:1];
			sq_mx = sq_mx >> 1;
			sq_my = sq_my >> 1;
			sq_mz = sq_mz >> 1;
		end
	end

	// Two restoring square root steps per cycle; the root is the floor of the exact root.
	always_comb begin
		rt_rad  = rad_q;
		rt_root = root_q;
		rt_rem  = rem_q;
		rt_cur  = '0;
		rt_try  = '0;
		for (int j = 0; j < 2; j++) begin
			rt_cur = {rt_rem, rt_rad[RAD_W-1 -: 2]};
			rt_try = TRY_W'({rt_root, 2'b01});
			if (rt_cur >= rt_try) begin
				rt_rem  = REM_W'(rt_cur - rt_try);
				rt_root = {rt_root[RT_W-2:0], 1'b1};
			end else begin
				rt_rem  = REM_W'(rt_cur);
				rt_root = {rt_root[RT_W-2:0], 1'b0};
			end
			rt_rad = {rt_rad[RAD_W-3:0], 2'b00};
		end
	end

	// Saturating add of the distance into the total.
	always_comb begin
		acc_sum  = SUM_W'(total_q) + SUM_W'(root_q);
		acc_next = (|acc_sum[SUM_W-1:TOTAL_WIDTH]) ? '1 : acc_sum[TOTAL_WIDTH-1:0];
	end

	// Control state, running total and the output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pla_pkg::ST_IDLE;
			have_prev_q    <= 1'b0;
			total_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// The output register fills when the final add goes through and empties
			// when the receiver takes the result.
			if (state_q == pla_pkg::ST_ACCUM && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				pla_pkg::ST_IDLE: begin
					if (accept) begin
						if (is_clear) begin
							total_q <= '0;
						end else begin
							have_prev_q <= 1'b1;
							state_q     <= have_prev_q ? pla_pkg::ST_SQUARE : pla_pkg::ST_ACCUM;
						end
					end
				end
				pla_pkg::ST_SQUARE: begin
					if (cnt_q == '0) begin
						state_q <= pla_pkg::ST_ROOT;
					end
				end
				pla_pkg::ST_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= pla_pkg::ST_ACCUM;
					end
				end
				pla_pkg::ST_ACCUM: begin
					if (out_free) begin
						total_q <= acc_next;
						state_q <= pla_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pla_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			pla_pkg::ST_IDLE: begin
				if (accept && !is_clear) begin
					prev_x_q <= pos_x;
					prev_y_q <= pos_y;
					prev_z_q <= pos_z;
					dx_q     <= ad_x;
					dy_q     <= ad_y;
					dz_q     <= ad_z;
					mx_q     <= RT_W'(ad_x);
					my_q     <= RT_W'(ad_y);
					mz_q     <= RT_W'(ad_z);
					hi_q     <= '0;
					lo_q     <= '0;
					cnt_q    <= CNT_LAST;
					// A first sample adds nothing.
					root_q   <= '0;
				end
			end
			pla_pkg::ST_SQUARE: begin
				hi_q  <= sq_hi;
				lo_q  <= sq_lo;
				mx_q  <= sq_mx;
				my_q  <= sq_my;
				mz_q  <= sq_mz;
				if (cnt_q == '0) begin
					rad_q  <= RAD_W'({sq_hi, sq_lo});
					root_q <= '0;
					rem_q  <= '0;
					cnt_q  <= CNT_LAST;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			pla_pkg::ST_ROOT: begin
				rad_q  <= rt_rad;
				root_q <= rt_root;
				rem_q  <= rt_rem;
				cnt_q  <= cnt_q - 1'b1;
			end
			pla_pkg::ST_ACCUM: begin
				if (out_free) begin
					result_q <= pla_pkg::OUT_WIDTH'(acc_next);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- tb/path_length_checker.sv -----
module path_length_checker #(
	parameter int POS_WIDTH   = 32,
	parameter int TOTAL_WIDTH = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          request_valid,
	input  logic                          request_ready,
	input  logic                          command,
	input  logic [POS_WIDTH-1:0]          pos_x,
	input  logic [POS_WIDTH-1:0]          pos_y,
	input  logic [POS_WIDTH-1:0]          pos_z,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic [pla_pkg::OUT_WIDTH-1:0] total_distance,
	output int                            mismatch_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_W = pla_pkg::OUT_WIDTH;
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

	logic [POS_WIDTH-1:0]   last_x, last_y, last_z;
	logic                   have_position;
	logic [TOTAL_WIDTH-1:0] running_total;
	logic [REPORT_W-1:0]    expected_totals[$];

	// Square of the gap between two signed positions, taken one bit wider so the
	// full span from the most negative to the most positive value still fits.
	function automatic logic [127:0] squared_gap(input logic [POS_WIDTH-1:0] a,
			input logic [POS_WIDTH-1:0] b);
		logic signed [POS_WIDTH:0] gap;
		logic [POS_WIDTH:0]        span;
		gap = $signed(a) - $signed(b);
		span = gap[POS_WIDTH] ? -gap : gap;
		return 128'(span) * 128'(span);
	endfunction

	// Largest root whose square does not exceed the radicand, found bit by bit from the top.
	function automatic logic [63:0] floor_sqrt(input logic [127:0] radicand);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 40; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (128'(trial) * 128'(trial) <= radicand)
				root = trial;
		end
		return root;
	endfunction

	task automatic take_request(input logic cmd, input logic [POS_WIDTH-1:0] x,
			input logic [POS_WIDTH-1:0] y, input logic [POS_WIDTH-1:0] z);
		logic [127:0]         radicand;
		logic [63:0]          stride;
		logic [TOTAL_WIDTH:0] widened;
		if (cmd == pla_pkg::CMD_CLEAR) begin
			running_total = '0;
			return;
		end
		if (have_position) begin
			radicand = squared_gap(x, last_x) + squared_gap(y, last_y) + squared_gap(z, last_z);
			stride = floor_sqrt(radicand);
			widened = (TOTAL_WIDTH + 1)'(running_total) + (TOTAL_WIDTH + 1)'(stride);
			running_total = (widened > TOTAL_MAX) ? TOTAL_MAX : widened[TOTAL_WIDTH-1:0];
		end else begin
			have_position = 1'b1;
		end
		last_x = x;
		last_y = y;
		last_z = z;
		expected_totals.push_back(REPORT_W'(running_total));
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [REPORT_W-1:0] want;
		if (!arst_n) begin
			last_x = '0;
			last_y = '0;
			last_z = '0;
			have_position = 1'b0;
			running_total = '0;
			expected_totals.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			// A result leaving at this edge always belongs to an earlier request.
			if (result_valid && result_ready) begin
				if (expected_totals.size() == 0) begin
					mismatch_count++;
					$error("total_distance: expected none, actual %0d", total_distance);
				end else begin
					want = expected_totals.pop_front();
					if (total_distance !== want) begin
						mismatch_count++;
						$error("total_distance: expected %0d, actual %0d", want,
							total_distance);
					end
				end
			end
			if (request_valid && request_ready)
				take_request(command, pos_x, pos_y, pos_z);
			outstanding = expected_totals.size();
		end
	end

endmodule

// ----- tb/path_length_accumulator_tb.sv -----
module path_length_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_WIDTH   = 32;
	localparam int TOTAL_WIDTH = 48;

	localparam logic [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
	localparam logic [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
	localparam logic [POS_WIDTH-1:0] ONE_METRE = POS_WIDTH'(32'h0001_0000);

	// A sample with a stored position has its result only after squaring, root and add.
	// The watchdog allows far more than that plus the longest gap and stall.
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 1000;

	// Jumps between opposite corners, the longest steps there are, sent at full rate.
	localparam int CORNER_STEPS = 20;

	localparam int RANDOM_CHUNKS = 10;
	localparam int CHUNK_ITEMS   = 50;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          request_valid = 1'b0;
	logic                          request_ready;
	logic                          command = pla_pkg::CMD_SAMPLE;
	logic [POS_WIDTH-1:0]          pos_x = '0;
	logic [POS_WIDTH-1:0]          pos_y = '0;
	logic [POS_WIDTH-1:0]          pos_z = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [pla_pkg::OUT_WIDTH-1:0] total_distance;

	int mismatch_count;
	int outstanding;
	int quiet_cycles = 0;

	// Idling switches for the two sides; the main sequence flips them per phase.
	bit sender_gaps = 1'b1;
	bit receiver_stalls = 1'b1;

	// Last position sent with a sample request, the base for random walks.
	logic [POS_WIDTH-1:0] walk_x = '0;
	logic [POS_WIDTH-1:0] walk_y = '0;
	logic [POS_WIDTH-1:0] walk_z = '0;

	path_length_accumulator #(
		.POS_WIDTH  (POS_WIDTH),
		.TOTAL_WIDTH(TOTAL_WIDTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_ready (request_ready),
		.command       (command),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.total_distance(total_distance)
	);

	// The checker sees the same wires as the block. It keeps its own copy of the
	// stored position and the running total, predicts every reported total, and
	// tells the top how many failures it found and how many totals are still due.
	path_length_checker #(
		.POS_WIDTH  (POS_WIDTH),
		.TOTAL_WIDTH(TOTAL_WIDTH)
	) odometer_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_ready (request_ready),
		.command       (command),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.total_distance(total_distance),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver mostly takes results at once but, while stalls are enabled,
	// now and then holds ready low for a burst of random length.
	initial begin
		forever begin
			@(posedge clk);
			if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	// The run is stopped if neither channel moves anything for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((request_valid && request_ready) || (result_valid && result_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("path_length_accumulator_tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Presents one request and returns at the edge where it is taken. Ready is
	// looked at on the falling edge, when it is settled for the next rising edge.
	// If another request follows right away, valid simply stays high.
	task automatic send_request(input logic cmd, input logic [POS_WIDTH-1:0] x,
			input logic [POS_WIDTH-1:0] y, input logic [POS_WIDTH-1:0] z);
		bit took;
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			request_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		request_valid <= 1'b1;
		command <= cmd;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do begin
			@(negedge clk);
			took = request_ready;
			@(posedge clk);
		end while (!took);
		if (cmd == pla_pkg::CMD_SAMPLE) begin
			walk_x = x;
			walk_y = y;
			walk_z = z;
		end
	endtask

	function automatic logic [POS_WIDTH-1:0] corner_value();
		case ($urandom_range(0, 3))
			0: return POS_MIN;
			1: return POS_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// A small signed step around a base, with a reach from one LSB up to 2^24 LSBs.
	function automatic logic [POS_WIDTH-1:0] nudge(input logic [POS_WIDTH-1:0] base);
		int unsigned reach;
		reach = 1 << $urandom_range(0, 24);
		return base + POS_WIDTH'($urandom_range(0, 2 * reach)) - POS_WIDTH'(reach);
	endfunction

	// Random requests: mostly position samples that wander a short way from the
	// last position, mixed with jumps anywhere in the range, corner positions,
	// repeats of the same position and the occasional clear.
	task automatic send_random_request();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			send_request(pla_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
		else if (pick < 33)
			send_request(pla_pkg::CMD_SAMPLE, $urandom(), $urandom(), $urandom());
		else if (pick < 43)
			send_request(pla_pkg::CMD_SAMPLE, corner_value(), corner_value(), corner_value());
		else if (pick < 47)
			send_request(pla_pkg::CMD_SAMPLE, walk_x, walk_y, walk_z);
		else
			send_request(pla_pkg::CMD_SAMPLE, nudge(walk_x), nudge(walk_y), nudge(walk_z));
	endtask

	initial begin
		int unsigned idle_mode;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests. A clear before any sample must not make the next
		// sample count a distance; that sample only stores its position.
		send_request(pla_pkg::CMD_CLEAR, '1, '1, '1);
		send_request(pla_pkg::CMD_SAMPLE, POS_MAX, POS_MIN, '0);
		// Same position again, so the distance is zero.
		send_request(pla_pkg::CMD_SAMPLE, POS_MAX, POS_MIN, '0);
		// Full span on x and y (z only from zero), then full span on every axis back.
		send_request(pla_pkg::CMD_SAMPLE, POS_MIN, POS_MAX, POS_MAX);
		send_request(pla_pkg::CMD_SAMPLE, POS_MAX, POS_MIN, POS_MIN);
		// A clear zeroes the total but keeps the stored position; its position
		// fields carry junk that must be ignored.
		send_request(pla_pkg::CMD_CLEAR, 32'h1234_5678, POS_MIN, POS_MAX);
		send_request(pla_pkg::CMD_SAMPLE, POS_MAX, POS_MIN, POS_MIN + 1);
		// Two clears back to back.
		send_request(pla_pkg::CMD_CLEAR, '0, '0, '0);
		send_request(pla_pkg::CMD_CLEAR, '1, '0, '1);
		// Mostly short moves where the root is exact or has to be truncated.
		send_request(pla_pkg::CMD_SAMPLE, '0, '0, '0);
		send_request(pla_pkg::CMD_SAMPLE, 1, 0, 0);
		send_request(pla_pkg::CMD_SAMPLE, 2, 1, 0);
		send_request(pla_pkg::CMD_SAMPLE, 3, 2, 1);
		send_request(pla_pkg::CMD_SAMPLE, 5, 4, '1);
		send_request(pla_pkg::CMD_SAMPLE, 8, 8, 1);
		send_request(pla_pkg::CMD_SAMPLE, '1, '1, '1);
		send_request(pla_pkg::CMD_SAMPLE, ONE_METRE, '1, '1);
		send_request(pla_pkg::CMD_SAMPLE, ONE_METRE, ONE_METRE, '0);
		send_request(pla_pkg::CMD_SAMPLE, POS_MIN, POS_MIN, POS_MIN);

		// Random requests in chunks, each with its own random mix of sender gaps and
		// receiver stalls, which can include chunks where neither side idles.
		for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
			idle_mode = $urandom_range(0, 3);
			sender_gaps = idle_mode[0];
			receiver_stalls = idle_mode[1];
			for (int n = 0; n < CHUNK_ITEMS; n++)
				send_random_request();
		end

		// Last part, at full rate: jump between opposite corners so the total
		// grows by the largest steps, then clear it and see counting resume
		// from zero.
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		send_request(pla_pkg::CMD_CLEAR, '0, '0, '0);
		for (int n = 0; n < CORNER_STEPS; n++) begin
			if (n % 2 == 0)
				send_request(pla_pkg::CMD_SAMPLE, POS_MAX, POS_MAX, POS_MAX);
			else
				send_request(pla_pkg::CMD_SAMPLE, POS_MIN, POS_MIN, POS_MIN);
		end
		send_request(pla_pkg::CMD_CLEAR, POS_MAX, POS_MAX, POS_MAX);
		send_request(pla_pkg::CMD_SAMPLE, '0, '0, '0);
		send_request(pla_pkg::CMD_SAMPLE, ONE_METRE, ONE_METRE, ONE_METRE);
		request_valid <= 1'b0;

		// Drain every expected total, then let the clock run for SETTLE_CYCLES before the verdict.
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);

		if (mismatch_count == 0)
			$display("path_length_accumulator_tb OK");
		else
			$display("path_length_accumulator_tb NOT OK");
		$finish;
	end

endmodule
